// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TVC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TVC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/tvc_pkg.sv
package tvc_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int CNT_W        = 16;
  localparam int TEMP_W       = 12;

  localparam int BTN_ON   = 0;
  localparam int BTN_OFF  = 1;
  localparam int BTN_DOWN = 2;
  localparam int BTN_UP   = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic signed [TEMP_W-1:0] SP_MIN     = -12'sd400;
  localparam logic signed [TEMP_W-1:0] SP_MAX     = 12'sd1250;
  localparam logic signed [TEMP_W-1:0] SP_RESET   = 12'sd200;
  localparam logic signed [TEMP_W-1:0] TEMP_RESET = 12'sd200;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [15:0] PERIOD_RESET   = 16'd200;
  localparam logic [7:0]  BAND_RESET     = 8'd10;
  localparam logic [7:0]  STEP_RESET     = 8'd5;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_TEMP     = 3'd1,
    KIND_ON       = 3'd2,
    KIND_OFF      = 3'd3,
    KIND_SETPOINT = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MOVE_NONE  = 2'd0,
    MOVE_OPEN  = 2'd1,
    MOVE_CLOSE = 2'd2
  } move_t;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_PERIOD   = 2'd1,
    CFG_BAND     = 2'd2,
    CFG_STEP     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] check_period_ticks;
    logic [7:0]  hysteresis_band;
    logic [7:0]  setpoint_step;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                kind;
    logic [BUTTON_COUNT-1:0]   button_levels;
    logic signed [TEMP_W-1:0]  temperature;
    logic                      temperature_valid;
    logic signed [TEMP_W-1:0]  new_setpoint;
  } item_t;

  typedef struct packed {
    logic                      system_on;
    logic                      heater_open;
    move_t                     valve_move;
    logic signed [TEMP_W-1:0]  setpoint;
    logic                      setpoint_changed;
    logic                      state_changed;
  } result_t;

endpackage

// File: sv/tvc_debounce.sv
module tvc_debounce (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_i,
  input  logic [tvc_pkg::BUTTON_COUNT-1:0] levels_i,
  input  logic [15:0]                      debounce_ticks_i,
  output logic [tvc_pkg::BUTTON_COUNT-1:0] press_o
);
  import tvc_pkg::*;

  logic [BUTTON_COUNT-1:0] prev_r;
  logic [BUTTON_COUNT-1:0] stable_r;
  logic [BUTTON_COUNT-1:0] stable_nxt;
  logic [CNT_W-1:0]        cnt_r   [BUTTON_COUNT];
  logic [CNT_W-1:0]        cnt_nxt [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] accept;

  always_comb begin
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      if (levels_i[i] != prev_r[i]) begin
        cnt_nxt[i] = '0;
      end else if (cnt_r[i] == CNT_MAX) begin
        cnt_nxt[i] = cnt_r[i];
      end else begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end
      accept[i]     = (cnt_nxt[i] > debounce_ticks_i) && (levels_i[i] != stable_r[i]);
      stable_nxt[i] = accept[i] ? levels_i[i] : stable_r[i];
      // active low: a press is the accepted level dropping to 0
      press_o[i]    = accept[i] && !levels_i[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '1;
      stable_r <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        cnt_r[i] <= CNT_MAX;
      end
    end else if (step_i) begin
      prev_r   <= levels_i;
      stable_r <= stable_nxt;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

// File: sv/tvc_core.sv
`include "assert_macros.svh"

module tvc_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_i,
  input  tvc_pkg::item_t                   item_i,
  input  logic [tvc_pkg::BUTTON_COUNT-1:0] press_i,
  input  tvc_pkg::cfg_t                    cfg_i,
  output tvc_pkg::result_t                 res_o
);
  import tvc_pkg::*;

  logic                     enabled_r,    enabled_nxt;
  logic                     valve_open_r, valve_open_nxt;
  logic signed [TEMP_W-1:0] setpoint_r,   setpoint_nxt;
  logic signed [TEMP_W-1:0] temp_r,       temp_nxt;
  logic                     temp_valid_r, temp_valid_nxt;
  logic [CNT_W-1:0]         check_cnt_r,  check_cnt_nxt;
  logic [CNT_W-1:0]         check_inc;
  move_t                    move;
  move_t                    chk_move;

  function automatic logic signed [TEMP_W-1:0] clamp_sp(input logic signed [TEMP_W:0] v);
    logic signed [TEMP_W:0] lo;
    logic signed [TEMP_W:0] hi;
    lo = {SP_MIN[TEMP_W-1], SP_MIN};
    hi = {SP_MAX[TEMP_W-1], SP_MAX};
    if (v < lo) begin
      return SP_MIN;
    end else if (v > hi) begin
      return SP_MAX;
    end
    return v[TEMP_W-1:0];
  endfunction

  // band check against the stored reading; opens below sp-band, closes above sp+band
  function automatic move_t hyst_move(input logic valid, input logic open,
                                      input logic signed [TEMP_W-1:0] t,
                                      input logic signed [TEMP_W-1:0] sp,
                                      input logic [7:0] band);
    logic signed [TEMP_W+1:0] tx;
    logic signed [TEMP_W+1:0] lo;
    logic signed [TEMP_W+1:0] hi;
    tx = {{2{t[TEMP_W-1]}}, t};
    lo = {{2{sp[TEMP_W-1]}}, sp} - {{(TEMP_W-6){1'b0}}, band};
    hi = {{2{sp[TEMP_W-1]}}, sp} + {{(TEMP_W-6){1'b0}}, band};
    if (!valid) begin
      return MOVE_NONE;
    end else if (!open && (tx < lo)) begin
      return MOVE_OPEN;
    end else if (open && (tx > hi)) begin
      return MOVE_CLOSE;
    end
    return MOVE_NONE;
  endfunction

  assign check_inc = (check_cnt_r == CNT_MAX) ? check_cnt_r : check_cnt_r + 1'b1;

  always_comb begin
    enabled_nxt    = enabled_r;
    valve_open_nxt = valve_open_r;
    setpoint_nxt   = setpoint_r;
    temp_nxt       = temp_r;
    temp_valid_nxt = temp_valid_r;
    check_cnt_nxt  = check_cnt_r;
    move           = MOVE_NONE;
    chk_move       = MOVE_NONE;
    case (kind_t'(item_i.kind))
      KIND_TICK: begin
        // presses take effect in the order on, off, down, up
        if (press_i[BTN_ON]) begin
          enabled_nxt = 1'b1;
        end
        if (press_i[BTN_OFF]) begin
          enabled_nxt = 1'b0;
          if (valve_open_nxt) begin
            valve_open_nxt = 1'b0;
            move           = MOVE_CLOSE;
          end
        end
        if (press_i[BTN_DOWN]) begin
          setpoint_nxt = clamp_sp({setpoint_nxt[TEMP_W-1], setpoint_nxt}
                                  - {5'd0, cfg_i.setpoint_step});
        end
        if (press_i[BTN_UP]) begin
          setpoint_nxt = clamp_sp({setpoint_nxt[TEMP_W-1], setpoint_nxt}
                                  + {5'd0, cfg_i.setpoint_step});
        end
        check_cnt_nxt = check_inc;
        if (enabled_nxt && (check_inc >= cfg_i.check_period_ticks)) begin
          check_cnt_nxt = '0;
          chk_move = hyst_move(temp_valid_r, valve_open_nxt, temp_r, setpoint_nxt,
                               cfg_i.hysteresis_band);
        end
      end
      KIND_TEMP: begin
        temp_nxt       = item_i.temperature;
        temp_valid_nxt = item_i.temperature_valid;
      end
      KIND_ON: begin
        enabled_nxt = 1'b1;
      end
      KIND_OFF: begin
        enabled_nxt = 1'b0;
        if (valve_open_r) begin
          valve_open_nxt = 1'b0;
          move           = MOVE_CLOSE;
        end
      end
      KIND_SETPOINT: begin
        setpoint_nxt = clamp_sp({item_i.new_setpoint[TEMP_W-1], item_i.new_setpoint});
        if (enabled_r) begin
          chk_move = hyst_move(temp_valid_r, valve_open_r, temp_r, setpoint_nxt, 8'd0);
        end
      end
      default: begin
      end
    endcase
    case (chk_move)
      MOVE_OPEN: begin
        valve_open_nxt = 1'b1;
        move           = MOVE_OPEN;
      end
      MOVE_CLOSE: begin
        valve_open_nxt = 1'b0;
        move           = MOVE_CLOSE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_o.system_on        = enabled_nxt;
    res_o.heater_open      = valve_open_nxt;
    res_o.valve_move       = move;
    res_o.setpoint         = setpoint_nxt;
    res_o.setpoint_changed = (setpoint_nxt != setpoint_r);
    res_o.state_changed    = (enabled_nxt != enabled_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b1;
      valve_open_r <= 1'b0;
      setpoint_r   <= SP_RESET;
      temp_r       <= TEMP_RESET;
      temp_valid_r <= 1'b1;
      check_cnt_r  <= '0;
    end else if (step_i) begin
      enabled_r    <= enabled_nxt;
      valve_open_r <= valve_open_nxt;
      setpoint_r   <= setpoint_nxt;
      temp_r       <= temp_nxt;
      temp_valid_r <= temp_valid_nxt;
      check_cnt_r  <= check_cnt_nxt;
    end
  end

  `TVC_ASSERT(a_off_closed, clk, rst_n, !enabled_r |-> !valve_open_r, "valve open while off")
  `TVC_ASSERT(a_sp_range, clk, rst_n, (setpoint_r >= SP_MIN) && (setpoint_r <= SP_MAX), "setpoint out of range")
  `TVC_ASSERT(a_move_tracks, clk, rst_n, step_i |-> ((res_o.heater_open != valve_open_r) == (res_o.valve_move != MOVE_NONE)), "valve move does not match position change")

endmodule

// File: sv/thermostat_valve_controller.sv
// Thermostat valve controller: on/off heating with a hysteresis band.
// A word taken into the input stage (item_r) has its result registered in out_r, on out_*.
// Throughput: one word per cycle; in_ready drops only while the input stage is full and the
// result register is full and stalled. Reset (rst_n, synchronous, active low) empties both
// stages, loads the default registers and the reset state at once; there is no clearing pass.
`include "assert_macros.svh"

module thermostat_valve_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic [3:0]          in_button_levels,
  input  logic signed [11:0]  in_temperature,
  input  logic                in_temperature_valid,
  input  logic signed [11:0]  in_new_setpoint,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_system_on,
  output logic                out_heater_open,
  output logic [1:0]          out_valve_move,
  output logic signed [11:0]  out_setpoint,
  output logic                out_setpoint_changed,
  output logic                out_state_changed,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import tvc_pkg::*;

  cfg_t                    cfg_r;
  item_t                   item_r;
  logic                    v1_r;
  result_t                 out_r;
  logic                    out_valid_r;
  logic                    out_free;
  logic                    step;
  logic [BUTTON_COUNT-1:0] press;
  result_t                 res;

  assign out_free = !out_valid_r || out_ready;
  assign step     = v1_r && out_free;
  assign in_ready = !v1_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= DEBOUNCE_RESET;
      cfg_r.check_period_ticks <= PERIOD_RESET;
      cfg_r.hysteresis_band    <= BAND_RESET;
      cfg_r.setpoint_step      <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE: cfg_r.debounce_ticks     <= cfg_wdata;
        CFG_PERIOD:   cfg_r.check_period_ticks <= cfg_wdata;
        CFG_BAND:     cfg_r.hysteresis_band    <= cfg_wdata[7:0];
        CFG_STEP:     cfg_r.setpoint_step      <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        v1_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind              <= in_kind;
      item_r.button_levels     <= in_button_levels;
      item_r.temperature       <= in_temperature;
      item_r.temperature_valid <= in_temperature_valid;
      item_r.new_setpoint      <= in_new_setpoint;
    end
    if (step) begin
      out_r <= res;
    end
  end

  tvc_debounce u_debounce (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_i           (step && (item_r.kind == KIND_TICK)),
    .levels_i         (item_r.button_levels),
    .debounce_ticks_i (cfg_r.debounce_ticks),
    .press_o          (press)
  );

  tvc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_i  (step),
    .item_i  (item_r),
    .press_i (press),
    .cfg_i   (cfg_r),
    .res_o   (res)
  );

  assign out_valid            = out_valid_r;
  assign out_system_on        = out_r.system_on;
  assign out_heater_open      = out_r.heater_open;
  assign out_valve_move       = out_r.valve_move;
  assign out_setpoint         = out_r.setpoint;
  assign out_setpoint_changed = out_r.setpoint_changed;
  assign out_state_changed    = out_r.state_changed;

  // a word held in the input stage stays there until the result register frees up
  `TVC_ASSERT(a_stage_holds, clk, rst_n, (v1_r && !out_free) |=> v1_r, "stalled word lost")
  `TVC_ASSERT(a_stage_moves, clk, rst_n, step |=> out_valid_r, "processed word not shown")
  `TVC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!out_valid_r && !v1_r), "stages not empty")

endmodule

// File: tb/sv/thermostat_checker.sv
`timescale 1ns / 1ps

module thermostat_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [2:0]          in_kind,
  input  logic [3:0]          in_button_levels,
  input  logic signed [11:0]  in_temperature,
  input  logic                in_temperature_valid,
  input  logic signed [11:0]  in_new_setpoint,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_system_on,
  input  logic                out_heater_open,
  input  logic [1:0]          out_valve_move,
  input  logic signed [11:0]  out_setpoint,
  input  logic                out_setpoint_changed,
  input  logic                out_state_changed,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata,
  output int                  failures,
  output int                  pending
);
  import tvc_pkg::*;

  cfg_t                     cfg;
  logic [3:0]               prev_lv;
  logic [3:0]               stable_lv;
  logic [CNT_W-1:0]         deb_cnt [BUTTON_COUNT];
  logic [CNT_W-1:0]         chk_cnt;
  logic signed [TEMP_W-1:0] temp_stored;
  logic signed [TEMP_W-1:0] sp;
  logic                     temp_ok;
  logic                     sys_on;
  logic                     valve_is_open;
  result_t                  due_results [$];
  int                       errs = 0;
  int                       n_out = 0;

  assign failures = errs;

  task automatic report(string msg);
    $display("%0t: %s", $time, msg);
    errs++;
  endtask

  function automatic logic signed [TEMP_W-1:0] clamp_sp(int v);
    if (v < int'(SP_MIN)) return SP_MIN;
    if (v > int'(SP_MAX)) return SP_MAX;
    return v[TEMP_W-1:0];
  endfunction

  // no move at all while the sensor reading is flagged bad
  function automatic move_t valve_check(int band);
    if (!temp_ok) return MOVE_NONE;
    if (!valve_is_open && int'(temp_stored) < int'(sp) - band) begin
      valve_is_open = 1'b1;
      return MOVE_OPEN;
    end
    if (valve_is_open && int'(temp_stored) > int'(sp) + band) begin
      valve_is_open = 1'b0;
      return MOVE_CLOSE;
    end
    return MOVE_NONE;
  endfunction

  function automatic move_t shut_down();
    sys_on = 1'b0;
    if (valve_is_open) begin
      valve_is_open = 1'b0;
      return MOVE_CLOSE;
    end
    return MOVE_NONE;
  endfunction

  function automatic result_t step_thermostat(item_t w);
    logic                     was_on;
    logic signed [TEMP_W-1:0] old_sp;
    move_t                    mv;
    move_t                    m;
    logic                     lv;
    result_t                  res;
    was_on = sys_on;
    old_sp = sp;
    mv = MOVE_NONE;
    case (w.kind)
      KIND_TICK: begin
        // presses within one tick are taken in button order: on, off, down, up
        for (int i = 0; i < BUTTON_COUNT; i++) begin
          lv = w.button_levels[i];
          if (lv != prev_lv[i]) deb_cnt[i] = '0;
          else if (deb_cnt[i] != CNT_MAX) deb_cnt[i] = deb_cnt[i] + 1'b1;
          if (deb_cnt[i] > cfg.debounce_ticks && lv != stable_lv[i]) begin
            stable_lv[i] = lv;
            if (!lv) begin
              if (i == BTN_ON) begin
                sys_on = 1'b1;
              end else if (i == BTN_OFF) begin
                m = shut_down();
                if (m != MOVE_NONE) mv = m;
              end else if (i == BTN_DOWN) begin
                sp = clamp_sp(int'(sp) - int'(cfg.setpoint_step));
              end else begin
                sp = clamp_sp(int'(sp) + int'(cfg.setpoint_step));
              end
            end
          end
        end
        prev_lv = w.button_levels;
        // the period counter keeps running while off
        if (chk_cnt != CNT_MAX) chk_cnt = chk_cnt + 1'b1;
        if (sys_on && chk_cnt >= cfg.check_period_ticks) begin
          chk_cnt = '0;
          m = valve_check(int'(cfg.hysteresis_band));
          if (m != MOVE_NONE) mv = m;
        end
      end
      KIND_TEMP: begin
        temp_stored = w.temperature;
        temp_ok = w.temperature_valid;
      end
      KIND_ON: sys_on = 1'b1;
      KIND_OFF: mv = shut_down();
      KIND_SETPOINT: begin
        sp = clamp_sp(int'($signed(w.new_setpoint)));
        if (sys_on) mv = valve_check(0);
      end
      default: ;
    endcase
    res.system_on = sys_on;
    res.heater_open = valve_is_open;
    res.valve_move = mv;
    res.setpoint = sp;
    res.setpoint_changed = (sp != old_sp);
    res.state_changed = (sys_on != was_on);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    item_t   w;
    result_t want;
    if (!rst_n) begin
      cfg.debounce_ticks = DEBOUNCE_RESET;
      cfg.check_period_ticks = PERIOD_RESET;
      cfg.hysteresis_band = BAND_RESET;
      cfg.setpoint_step = STEP_RESET;
      prev_lv = '1;
      stable_lv = '0;
      foreach (deb_cnt[i]) deb_cnt[i] = CNT_MAX;
      chk_cnt = '0;
      temp_stored = TEMP_RESET;
      temp_ok = 1'b1;
      sys_on = 1'b1;
      valve_is_open = 1'b0;
      sp = SP_RESET;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: cfg.debounce_ticks = cfg_wdata;
          CFG_PERIOD:   cfg.check_period_ticks = cfg_wdata;
          CFG_BAND:     cfg.hysteresis_band = cfg_wdata[7:0];
          CFG_STEP:     cfg.setpoint_step = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        w.kind = in_kind;
        w.button_levels = in_button_levels;
        w.temperature = in_temperature;
        w.temperature_valid = in_temperature_valid;
        w.new_setpoint = in_new_setpoint;
        due_results.push_back(step_thermostat(w));
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (due_results.size() == 0) begin
          report($sformatf("word %0d arrived with nothing expected", n_out));
        end else begin
          want = due_results.pop_front();
          if (out_system_on !== want.system_on)
            report($sformatf("word %0d system_on: got %0b expected %0b",
                             n_out, out_system_on, want.system_on));
          if (out_heater_open !== want.heater_open)
            report($sformatf("word %0d heater_open: got %0b expected %0b",
                             n_out, out_heater_open, want.heater_open));
          if (out_valve_move !== want.valve_move)
            report($sformatf("word %0d valve_move: got %0d expected %0d",
                             n_out, out_valve_move, want.valve_move));
          if (out_setpoint !== want.setpoint)
            report($sformatf("word %0d setpoint: got %0d expected %0d",
                             n_out, out_setpoint, $signed(want.setpoint)));
          if (out_setpoint_changed !== want.setpoint_changed)
            report($sformatf("word %0d setpoint_changed: got %0b expected %0b",
                             n_out, out_setpoint_changed, want.setpoint_changed));
          if (out_state_changed !== want.state_changed)
            report($sformatf("word %0d state_changed: got %0b expected %0b",
                             n_out, out_state_changed, want.state_changed));
        end
      end
    end
    pending <= due_results.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tvc_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_kind = '0;
  logic [3:0]         in_button_levels = '1;
  logic signed [11:0] in_temperature = '0;
  logic               in_temperature_valid = 1'b0;
  logic signed [11:0] in_new_setpoint = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_system_on;
  logic               out_heater_open;
  logic [1:0]         out_valve_move;
  logic signed [11:0] out_setpoint;
  logic               out_setpoint_changed;
  logic               out_state_changed;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;
  int                 failures;
  int                 pending;
  int                 cycle_count = 0;
  int                 burst_left = 0;

  always #1 clk = ~clk;

  thermostat_valve_controller dut (.*);

  thermostat_checker chk (.*);

  // mostly near the reset setpoint, some across the range, a few any 12-bit value
  function automatic logic signed [TEMP_W-1:0] pick_temp();
    int                       r;
    logic signed [TEMP_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 70) v = 12'($urandom_range(0, 400));
    else if (r < 90) v = 12'(int'($urandom_range(0, 1650)) - 400);
    else v = 12'($urandom);
    return v;
  endfunction

  function automatic item_t word_of(logic [2:0] k);
    item_t w;
    w.kind = k;
    w.button_levels = 4'($urandom);
    w.temperature = pick_temp();
    w.temperature_valid = 1'($urandom);
    w.new_setpoint = pick_temp();
    return w;
  endfunction

  function automatic int idle_len();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic send(item_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= w.kind;
    in_button_levels <= w.button_levels;
    in_temperature <= w.temperature;
    in_temperature_valid <= w.temperature_valid;
    in_new_setpoint <= w.new_setpoint;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tick(logic [3:0] lv);
    item_t w;
    w = word_of(KIND_TICK);
    w.button_levels = lv;
    send(w);
  endtask

  task automatic send_temp(logic signed [TEMP_W-1:0] t, logic ok);
    item_t w;
    w = word_of(KIND_TEMP);
    w.temperature = t;
    w.temperature_valid = ok;
    send(w);
  endtask

  task automatic send_sp(logic signed [TEMP_W-1:0] v);
    item_t w;
    w = word_of(KIND_SETPOINT);
    w.new_setpoint = v;
    send(w);
  endtask

  // hold off until every word in flight has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic configure(logic [15:0] deb, logic [15:0] per, logic [7:0] band,
                           logic [7:0] step);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= CFG_PERIOD;
    cfg_wdata <= per;
    @(posedge clk);
    cfg_index <= CFG_BAND;
    cfg_wdata <= band;
    @(posedge clk);
    cfg_index <= CFG_STEP;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // button levels are held long enough to get through a debounce under 70 ticks, with some bounce
  task automatic run_phase(int deb, int n, int tick_pct);
    item_t      w;
    logic [3:0] held;
    int         hold_left;
    int         r;
    held = '1;
    hold_left = 0;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
        if ($urandom_range(0, 99) < (deb < 10 ? 10 : 1)) begin
          send_tick(4'($urandom));
        end else begin
          if (hold_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 40) held = '1;
            else if (r < 85) held = ~(4'b1 << $urandom_range(0, BUTTON_COUNT - 1));
            else held = 4'($urandom);
            hold_left = (deb < 70) ? deb + $urandom_range(1, 3) : $urandom_range(1, 20);
          end
          send_tick(held);
          hold_left--;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) begin
          w = word_of(KIND_TEMP);
          w.temperature_valid = ($urandom_range(0, 99) < 85);
          send(w);
        end else if (r < 50) begin
          send(word_of(KIND_ON));
        end else if (r < 65) begin
          send(word_of(KIND_OFF));
        end else if (r < 95) begin
          send(word_of(KIND_SETPOINT));
        end else begin
          send(word_of(3'($urandom_range(KIND_SETPOINT + 1, 7))));
        end
      end
    end
  endtask

  initial begin
    @(posedge clk);
    forever begin : receiver
      int r;
      int len;
      r = $urandom_range(0, 99);
      if (r < 55) begin
        out_ready <= 1'b1;
        len = $urandom_range(1, 8);
      end else if (r < 85) begin
        out_ready <= 1'b0;
        len = $urandom_range(1, 3);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        len = $urandom_range(4, 30);
      end else begin
        out_ready <= 1'b1;
        len = $urandom_range(40, 150);
      end
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int deb;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: remote commands, range limits, bad sensor, spare kinds
    send_tick('1);
    send_temp(12'sd100, 1'b1);
    send_sp(12'sd300);
    send_temp(12'sd400, 1'b1);
    send_sp(12'sd200);
    send_temp(-12'sd400, 1'b1);
    send_sp(12'h7FF);
    send(word_of(KIND_OFF));
    send_sp(12'h800);
    send(word_of(KIND_ON));
    send_temp(12'h7FF, 1'b0);
    send_sp(12'sd1250);
    send_temp(12'h800, 1'b1);
    send(word_of(3'(KIND_SETPOINT + 1)));
    send(word_of(3'd7));
    drain();

    // debounce of 1: all four buttons at once, then down with the widest step
    configure(16'd1, 16'd1, 8'd0, 8'd255);
    send_tick('1);
    repeat (3) send_tick('0);
    repeat (3) send_tick('1);
    repeat (3) send_tick(~(4'b1 << BTN_DOWN));
    drain();

    configure(16'd1, 16'd1, 8'd0, 8'd1);
    run_phase(1, 90, 60);
    drain();
    configure(16'd2, 16'd3, 8'd255, 8'd255);
    run_phase(2, 90, 65);
    drain();
    configure(16'hFFFF, 16'hFFFF, 8'd10, 8'd5);
    run_phase(65535, 50, 60);
    drain();
    configure(DEBOUNCE_RESET, PERIOD_RESET, BAND_RESET, STEP_RESET);
    run_phase(int'(DEBOUNCE_RESET), 220, 92);
    drain();
    repeat (3) begin
      deb = $urandom_range(1, 5);
      configure(16'(deb), 16'($urandom_range(1, 12)),
                ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 30)),
                8'($urandom_range(1, 40)));
      run_phase(deb, 100, 70);
      drain();
    end

    repeat (4) @(posedge clk);
    if (failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
